[rtl/psmf_pkg.sv]
// ============================================================================
// psmf_pkg: shared types, constants and pointer helpers
// Ring geometry, status codes, read sequencer states and ring pointer
// arithmetic used by the PS/2 mouse packet framer.
// ============================================================================
package psmf_pkg;

    // Ring geometry and packet length.
    localparam int RING_DEPTH = 64;
    localparam int PACKET_LEN = 3;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int BIP_W      = $clog2(PACKET_LEN);
    localparam int BYTE_W     = 8;

    localparam logic [PTR_W:0]    DEPTH_EXT = (PTR_W + 1)'(RING_DEPTH);
    localparam logic [BYTE_W-1:0] SYNC_MASK = 8'hc0;
    localparam logic [BYTE_W-1:0] ACK_RESET = 8'd250;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [BIP_W-1:0]  bip_t;
    typedef logic [BYTE_W-1:0] byte_t;

    localparam ptr_t PTR_ZERO = '0;
    localparam ptr_t PTR_ONE  = PTR_W'(1);
    localparam ptr_t PTR_TWO  = PTR_W'(2);
    localparam ptr_t PTR_PKT  = PTR_W'(PACKET_LEN);

    // Status code carried with every result beat.
    typedef enum logic [2:0] {
        ST_STORED = 3'd0,
        ST_ACK    = 3'd1,
        ST_SYNC   = 3'd2,
        ST_FLUSH  = 3'd3,
        ST_NONE   = 3'd4
    } status_t;

    // Read sequencer: which packet byte the ring read data holds.
    typedef enum logic [1:0] {
        RD_IDLE = 2'd0,
        RD_B0   = 2'd1,
        RD_B1   = 2'd2,
        RD_B2   = 2'd3
    } rd_state_t;

    // Outcome of framing one received byte.
    typedef struct packed {
        status_t status;
        logic    done;
        logic    store;
        ptr_t    ws_next;
        bip_t    bip_next;
    } frame_upd_t;

    // Sum of two ring pointers, wrapped at the ring depth.
    function automatic ptr_t ptr_add(ptr_t p, ptr_t k);
        logic [PTR_W:0] s;
        s = {1'b0, p} + {1'b0, k};
        if (s >= DEPTH_EXT) begin
            s = s - DEPTH_EXT;
        end
        return s[PTR_W-1:0];
    endfunction

    // Difference of two ring pointers, wrapped at the ring depth.
    function automatic ptr_t ptr_sub(ptr_t p, ptr_t k);
        logic [PTR_W:0] s;
        if (p >= k) begin
            s = {1'b0, p} - {1'b0, k};
        end else begin
            s = {1'b0, p} + DEPTH_EXT - {1'b0, k};
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

[rtl/psmf_ring_ram.sv]
// ============================================================================
// psmf_ring_ram: byte ring storage
// One write port and one read port; read data is registered and holds
// while the read enable is low.
// ============================================================================
module psmf_ring_ram (
    input  logic           aclk,
    input  logic           we,
    input  psmf_pkg::ptr_t waddr,
    input  psmf_pkg::byte_t wdata,
    input  logic           re,
    input  psmf_pkg::ptr_t raddr,
    output psmf_pkg::byte_t rdata
);

    psmf_pkg::byte_t mem [psmf_pkg::RING_DEPTH];
    psmf_pkg::byte_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/psmf_framer.sv]
// ============================================================================
// psmf_framer: classification of one received byte
// Decides whether a byte is dropped, stored or flushes the partial packet,
// and works out the next write slot and packet position.
// ============================================================================
module psmf_framer (
    input  psmf_pkg::byte_t     rx_byte,
    input  psmf_pkg::byte_t     ack_code,
    input  psmf_pkg::ptr_t      ws,
    input  psmf_pkg::ptr_t      lrs,
    input  psmf_pkg::bip_t      bip,
    output psmf_pkg::frame_upd_t upd
);

    logic [psmf_pkg::BIP_W:0] bip_inc;

    assign bip_inc = {1'b0, bip} + (psmf_pkg::BIP_W + 1)'(1);

    always_comb begin
        upd          = '0;
        upd.status   = psmf_pkg::ST_STORED;
        upd.ws_next  = ws;
        upd.bip_next = bip;
        if ((bip == '0) && (rx_byte == ack_code)) begin
            upd.status = psmf_pkg::ST_ACK;
        end else if ((bip == '0) && ((rx_byte & psmf_pkg::SYNC_MASK) != '0)) begin
            upd.status = psmf_pkg::ST_SYNC;
        end else if (ws != lrs) begin
            upd.store   = 1'b1;
            upd.ws_next = psmf_pkg::ptr_add(ws, psmf_pkg::PTR_ONE);
            if (bip_inc >= (psmf_pkg::BIP_W + 1)'(psmf_pkg::PACKET_LEN)) begin
                upd.done     = 1'b1;
                upd.bip_next = '0;
            end else begin
                upd.bip_next = bip_inc[psmf_pkg::BIP_W-1:0];
            end
        end else begin
            // Ring full: give back the slots of the partial packet.
            upd.status   = psmf_pkg::ST_FLUSH;
            upd.ws_next  = psmf_pkg::ptr_sub(ws, psmf_pkg::PTR_W'(bip));
            upd.bip_next = '0;
        end
    end

endmodule

[rtl/ps2_mouse_packet_framer_ring.sv]
// ============================================================================
// ps2_mouse_packet_framer_ring: PS/2 mouse packet framer with receive ring
// Frames mouse bytes into packets held in a byte ring and returns packets
// on read beats.
// ============================================================================
// Timing: a byte beat or a read of a ring with too few bytes has its result
//   registered in the cycle after acceptance. Throughput: one byte beat per cycle
//   while the output is free; a packet read holds the input until RD_B2 loads its
//   result, as its three bytes come one per cycle from the ring's read port.
// Reset: aresetn is synchronous and active low; it clears the write and last-read
//   pointers, packet position and handshake state, sets ACK code 250, keeps the ring.
module ps2_mouse_packet_framer_ring (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: ack_code.
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] func
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] packet_byte0, [15:8] packet_byte1,
                                   // [23:16] packet_byte2
    output logic [3:0]  m_tuser,   // [2:0] rx_status, [3] read_valid
    output logic        m_tlast    // packet_done
);

    // ------------------------------------------------------------------
    // Control state.
    // ------------------------------------------------------------------
    psmf_pkg::byte_t     ack_reg;
    psmf_pkg::ptr_t      ws_reg, ws_next;
    psmf_pkg::ptr_t      lrs_reg, lrs_next;
    psmf_pkg::bip_t      bip_reg, bip_next;
    psmf_pkg::ptr_t      rd_ptr_reg, rd_ptr_next;
    psmf_pkg::rd_state_t rd_state_reg, rd_state_next;
    logic                m_valid_reg, m_valid_next;

    // Result payload held in the output register.
    psmf_pkg::status_t   m_status_reg, m_status_next;
    logic                m_done_reg, m_done_next;
    logic                m_rdv_reg, m_rdv_next;
    psmf_pkg::byte_t     m_b0_reg, m_b0_next;
    psmf_pkg::byte_t     m_b1_reg, m_b1_next;
    psmf_pkg::byte_t     m_b2_reg, m_b2_next;

    // The first two packet bytes are parked here while the third is read.
    psmf_pkg::byte_t     pb0_reg, pb1_reg;

    // ------------------------------------------------------------------
    // Handshake and item decode.
    // ------------------------------------------------------------------
    logic                out_free;
    logic                accept;
    logic                is_read;
    logic                rd_ok;
    psmf_pkg::ptr_t      stored;
    psmf_pkg::frame_upd_t upd;

    // Sequencer outputs.
    logic                ram_re;
    logic                cap_b0;
    logic                cap_b1;
    logic                ld_packet;

    psmf_pkg::ptr_t      ram_raddr;
    psmf_pkg::byte_t     ram_rdata;

    // The output register may take a new result when it is empty or being
    // emptied in this very cycle; a waiting result blocks a beat while m_tready is low.
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (rd_state_reg == psmf_pkg::RD_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign is_read  = s_tuser[0];

    // The ring holds (write slot - last read slot - 1) bytes, modulo depth.
    assign stored = psmf_pkg::ptr_sub(ws_reg, psmf_pkg::ptr_add(lrs_reg, psmf_pkg::PTR_ONE));
    assign rd_ok  = stored >= psmf_pkg::PTR_PKT;

    psmf_framer u_framer (
        .rx_byte  (s_tdata),
        .ack_code (ack_reg),
        .ws       (ws_reg),
        .lrs      (lrs_reg),
        .bip      (bip_reg),
        .upd      (upd)
    );

    // ------------------------------------------------------------------
    // Ring memory. Bytes are written at the accept edge. While idle the read
    // port keeps fetching the slot after the last read one, so that a packet
    // read accepted at an edge has its first byte in the read register
    // straight after it. Writes are held off while a packet is being read,
    // so a slot cannot be overwritten under an outstanding read.
    // ------------------------------------------------------------------
    assign ram_raddr = (rd_state_reg == psmf_pkg::RD_IDLE)
                     ? psmf_pkg::ptr_add(lrs_reg, psmf_pkg::PTR_ONE)
                     : rd_ptr_reg;

    psmf_ring_ram u_ring (
        .aclk  (aclk),
        .we    (accept && !is_read && upd.store),
        .waddr (ws_reg),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Read sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        rd_state_next = rd_state_reg;
        case (rd_state_reg)
            psmf_pkg::RD_IDLE: begin
                if (accept && is_read && rd_ok) begin
                    rd_state_next = psmf_pkg::RD_B0;
                end
            end
            psmf_pkg::RD_B0: begin
                rd_state_next = psmf_pkg::RD_B1;
            end
            psmf_pkg::RD_B1: begin
                rd_state_next = psmf_pkg::RD_B2;
            end
            psmf_pkg::RD_B2: begin
                if (out_free) begin
                    rd_state_next = psmf_pkg::RD_IDLE;
                end
            end
            default: begin
                rd_state_next = psmf_pkg::RD_IDLE;
            end
        endcase
    end

    // Read sequencer: outputs. In the last state the read register already
    // holds the third byte and must hold it until the result is loaded.
    always_comb begin
        ram_re    = 1'b1;
        cap_b0    = 1'b0;
        cap_b1    = 1'b0;
        ld_packet = 1'b0;
        case (rd_state_reg)
            psmf_pkg::RD_IDLE: begin
                ram_re = 1'b1;
            end
            psmf_pkg::RD_B0: begin
                cap_b0 = 1'b1;
            end
            psmf_pkg::RD_B1: begin
                cap_b1 = 1'b1;
            end
            psmf_pkg::RD_B2: begin
                ram_re    = 1'b0;
                ld_packet = out_free;
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Pointer and output register updates.
    // ------------------------------------------------------------------
    always_comb begin
        ws_next       = ws_reg;
        lrs_next      = lrs_reg;
        bip_next      = bip_reg;
        rd_ptr_next   = rd_ptr_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_done_next   = m_done_reg;
        m_rdv_next    = m_rdv_reg;
        m_b0_next     = m_b0_reg;
        m_b1_next     = m_b1_reg;
        m_b2_next     = m_b2_reg;

        if (accept && !is_read) begin
            ws_next       = upd.ws_next;
            bip_next      = upd.bip_next;
            m_valid_next  = 1'b1;
            m_status_next = upd.status;
            m_done_next   = upd.done;
            m_rdv_next    = 1'b0;
            m_b0_next     = '0;
            m_b1_next     = '0;
            m_b2_next     = '0;
        end else if (accept && is_read && !rd_ok) begin
            // Too few bytes for a packet: nothing moves.
            m_valid_next  = 1'b1;
            m_status_next = psmf_pkg::ST_NONE;
            m_done_next   = 1'b0;
            m_rdv_next    = 1'b0;
            m_b0_next     = '0;
            m_b1_next     = '0;
            m_b2_next     = '0;
        end else if (accept && is_read) begin
            // The whole packet is released at once; the input stays closed
            // until its three bytes have been fetched and its result is loaded.
            lrs_next    = psmf_pkg::ptr_add(lrs_reg, psmf_pkg::PTR_PKT);
            rd_ptr_next = psmf_pkg::ptr_add(lrs_reg, psmf_pkg::PTR_TWO);
        end else if (ram_re && (rd_state_reg != psmf_pkg::RD_IDLE)) begin
            rd_ptr_next = psmf_pkg::ptr_add(rd_ptr_reg, psmf_pkg::PTR_ONE);
        end

        if (ld_packet) begin
            m_valid_next  = 1'b1;
            m_status_next = psmf_pkg::ST_NONE;
            m_done_next   = 1'b0;
            m_rdv_next    = 1'b1;
            m_b0_next     = pb0_reg;
            m_b1_next     = pb1_reg;
            m_b2_next     = ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_reg      <= psmf_pkg::ACK_RESET;
            ws_reg       <= psmf_pkg::PTR_ONE;
            lrs_reg      <= psmf_pkg::PTR_ZERO;
            bip_reg      <= '0;
            rd_state_reg <= psmf_pkg::RD_IDLE;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                ack_reg <= cfg_wdata;
            end
            ws_reg       <= ws_next;
            lrs_reg      <= lrs_next;
            bip_reg      <= bip_next;
            rd_state_reg <= rd_state_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg   <= rd_ptr_next;
        m_status_reg <= m_status_next;
        m_done_reg   <= m_done_next;
        m_rdv_reg    <= m_rdv_next;
        m_b0_reg     <= m_b0_next;
        m_b1_reg     <= m_b1_next;
        m_b2_reg     <= m_b2_next;
        if (cap_b0) begin
            pb0_reg <= ram_rdata;
        end
        if (cap_b1) begin
            pb1_reg <= ram_rdata;
        end
    end

    // ------------------------------------------------------------------
    // Result port.
    // ------------------------------------------------------------------
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_b2_reg, m_b1_reg, m_b0_reg};
    assign m_tuser  = {m_rdv_reg, m_status_reg};
    assign m_tlast  = m_done_reg;

`ifndef SYNTH
    // No beat is taken while a packet read is still fetching its bytes.
    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_state_reg != psmf_pkg::RD_IDLE) |-> !s_tready)
        else $error("input accepted during a packet read");

    // A stored byte never lands in the slot that keeps the ring from looking empty.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_read && upd.store) |-> (ws_reg != lrs_reg))
        else $error("ring write into a full ring");

    // The packet position stays below the packet length.
    a_bip_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, bip_reg} < (psmf_pkg::BIP_W + 1)'(psmf_pkg::PACKET_LEN)))
        else $error("packet position out of range");

    // The fetch steps through its first two bytes without pause.
    a_fetch_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_state_reg == psmf_pkg::RD_B0) |=> (rd_state_reg == psmf_pkg::RD_B1))
        else $error("packet fetch did not advance");

    // A packet result is loaded only with a valid read flag.
    a_packet_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ld_packet |=> (m_tvalid && m_tuser[3]))
        else $error("packet read result lost its valid flag");
`endif

endmodule
